// File: src/alss_pkg.sv
package alss_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_RED        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_GREEN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_BLUE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_EPSILON = 2'd3;

    localparam logic [CFG_DATA_W-1:0] RST_LIGHT   = 16'd256;
    localparam logic [CFG_DATA_W-1:0] RST_EPSILON = 16'd66;

    localparam int SQ_W       = 64;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = 32;

    typedef struct packed {
        logic signed [31:0] light_point_x;
        logic signed [31:0] light_point_y;
        logic signed [31:0] light_point_z;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic signed [15:0] light_normal_x;
        logic signed [15:0] light_normal_y;
        logic signed [15:0] light_normal_z;
        logic        [31:0] area_pdf;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [31:0] shadow_min_t;
        logic        [31:0] out_red;
        logic        [31:0] out_green;
        logic        [31:0] out_blue;
        logic               facing_away;
    } t_out_item;

endpackage

// File: src/alss_if.sv
interface alss_in_if;
    logic               valid;
    logic               ready;
    alss_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface alss_out_if;
    logic                valid;
    logic                ready;
    alss_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/alss_sqrt.sv
module alss_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [alss_pkg::SQ_W-1:0]   i_sq,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [alss_pkg::ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int STEPS = alss_pkg::SQRT_STEPS;
    localparam int W     = alss_pkg::SQ_W;

    logic [W-1:0]      r_x    [STEPS];
    logic [W-1:0]      r_r    [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];
    logic [STEPS-1:0]  r_v;

    for (genvar gi = 0; gi < STEPS; gi++) begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * gi);
        logic [W-1:0]      p_x;
        logic [W-1:0]      p_r;
        logic [SIDE_W-1:0] p_side;
        logic              p_v;
        logic [W:0]        t;
        logic [W-1:0]      n_x;
        logic [W-1:0]      n_r;

        if (gi == 0) begin : g_first
            assign p_x    = i_sq;
            assign p_r    = '0;
            assign p_side = i_side;
            assign p_v    = i_valid;
        end else begin : g_next
            assign p_x    = r_x[gi-1];
            assign p_r    = r_r[gi-1];
            assign p_side = r_side[gi-1];
            assign p_v    = r_v[gi-1];
        end

        always_comb begin
            t = {1'b0, p_r} + {1'b0, BIT};
            if ({1'b0, p_x} >= t) begin
                n_x = p_x - t[W-1:0];
                n_r = (p_r >> 1) + BIT;
            end else begin
                n_x = p_x;
                n_r = p_r >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi] <= 1'b0;
            end else if (i_en) begin
                r_v[gi] <= p_v;
            end
            if (i_en) begin
                r_x[gi]    <= n_x;
                r_r[gi]    <= n_r;
                r_side[gi] <= p_side;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_root  = r_r[STEPS-1][alss_pkg::ROOT_W-1:0];
    assign o_side  = r_side[STEPS-1];

endmodule

// File: src/alss_div.sv
module alss_div #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int Q_BITS = 15,
    parameter int LANES  = 3,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num [LANES],
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_BITS-1:0] o_quo [LANES],
    output logic [SIDE_W-1:0] o_side
);

    localparam int W = ((NUM_W > DEN_W + Q_BITS - 1) ? NUM_W : DEN_W + Q_BITS - 1) + 1;

    logic [NUM_W-1:0]  r_rem  [Q_BITS][LANES];
    logic [Q_BITS-1:0] r_q    [Q_BITS][LANES];
    logic [DEN_W-1:0]  r_den  [Q_BITS];
    logic [SIDE_W-1:0] r_side [Q_BITS];
    logic [Q_BITS-1:0] r_v;

    for (genvar gi = 0; gi < Q_BITS; gi++) begin : g_step
        localparam int J = Q_BITS - 1 - gi;
        logic [NUM_W-1:0]  p_rem [LANES];
        logic [Q_BITS-1:0] p_q   [LANES];
        logic [DEN_W-1:0]  p_den;
        logic [SIDE_W-1:0] p_side;
        logic              p_v;
        logic [W-1:0]      dsh;
        logic [NUM_W-1:0]  n_rem [LANES];
        logic [Q_BITS-1:0] n_q   [LANES];

        if (gi == 0) begin : g_first
            assign p_rem  = i_num;
            assign p_den  = i_den;
            assign p_side = i_side;
            assign p_v    = i_valid;
            for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
                assign p_q[gl] = '0;
            end
        end else begin : g_next
            assign p_rem  = r_rem[gi-1];
            assign p_q    = r_q[gi-1];
            assign p_den  = r_den[gi-1];
            assign p_side = r_side[gi-1];
            assign p_v    = r_v[gi-1];
        end

        always_comb begin
            dsh = W'(p_den) << J;
            for (int l = 0; l < LANES; l++) begin
                n_rem[l] = p_rem[l];
                n_q[l]   = p_q[l];
                if (W'(p_rem[l]) >= dsh) begin
                    n_rem[l]  = p_rem[l] - dsh[NUM_W-1:0];
                    n_q[l][J] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi] <= 1'b0;
            end else if (i_en) begin
                r_v[gi] <= p_v;
            end
            if (i_en) begin
                r_rem[gi]  <= n_rem;
                r_q[gi]    <= n_q;
                r_den[gi]  <= p_den;
                r_side[gi] <= p_side;
            end
        end
    end

    assign o_valid = r_v[Q_BITS-1];
    assign o_quo   = r_q[Q_BITS-1];
    assign o_side  = r_side[Q_BITS-1];

endmodule

// File: src/area_light_shadow_ray_setup.sv
// Shadow-ray setup toward one area-light sample. Takes one ray per cycle unless the output
// is stalled and gives one result per ray, in order: stages A to C form the difference and
// its squared length, the square root runs one result bit per stage, stage D forms the
// direction numerators, a divider by the length gives one quotient bit per stage, stages E
// to I form the cosine, the pdf times squared-length product and the scaled numerators, a
// second divider divides the colour (one quotient bit per stage plus an overflow bit for
// saturation), and the output register follows. The whole pipeline holds while a result
// waits at the output. The user must write the light colour and epsilon registers through
// the config port only while no ray is in flight; the block itself does not enforce this.
module area_light_shadow_ray_setup #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int UNIT_FRAC_BITS  = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    alss_in_if.sink                          i_in,
    alss_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [alss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [alss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int QD    = UNIT_FRAC_BITS + 1;
    localparam int E_S0  = 4 * COORD_FRAC_BITS - 8 - 2 * UNIT_FRAC_BITS;
    localparam int E_S1  = E_S0 - 2;
    localparam int UP_S0 = (E_S0 > 0) ? E_S0 : 0;
    localparam int UP_S1 = (E_S1 > 0) ? E_S1 : 0;
    localparam int DN_S0 = (E_S0 < 0) ? -E_S0 : 0;
    localparam int DN_S1 = (E_S1 < 0) ? -E_S1 : 0;
    localparam int NUM_C = 48 + UP_S0;
    localparam int DEN_C = 96 + DN_S1;
    localparam int QC    = 33;

    typedef struct packed {
        logic [2:0][30:0]        ms;
        logic [2:0]              neg;
        logic                    s;
        logic [63:0]             sq;
        logic [2:0][15:0]        nrm;
        logic [31:0]             pdf;
    } t_sqrt_side;

    typedef struct packed {
        logic [2:0]              neg;
        logic                    s;
        logic [31:0]             len;
        logic [63:0]             sq;
        logic [2:0][15:0]        nrm;
        logic [31:0]             pdf;
    } t_dir_side;

    typedef struct packed {
        logic [2:0]              nz;
        logic                    pos;
        logic [2:0][15:0]        dir;
        logic [31:0]             mint;
    } t_col_side;

    logic en;

    logic [15:0] r_light [3];
    logic [15:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light[0] <= alss_pkg::RST_LIGHT;
            r_light[1] <= alss_pkg::RST_LIGHT;
            r_light[2] <= alss_pkg::RST_LIGHT;
            r_eps      <= alss_pkg::RST_EPSILON;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                alss_pkg::CFG_LIGHT_RED:        r_light[0] <= i_cfg_data;
                alss_pkg::CFG_LIGHT_GREEN:      r_light[1] <= i_cfg_data;
                alss_pkg::CFG_LIGHT_BLUE:       r_light[2] <= i_cfg_data;
                alss_pkg::CFG_DISTANCE_EPSILON: r_eps      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    assign en          = !r_out_valid || o_out.ready;
    assign i_in.ready  = en;

    // Stage A: differences and magnitudes
    logic [31:0]        lp   [3];
    logic [31:0]        hp   [3];
    logic [32:0]        dd   [3];
    logic [32:0]        dneg [3];
    logic [31:0]        n_a_m [3];
    logic               r_a_v;
    logic [31:0]        r_a_m   [3];
    logic [2:0]         r_a_neg;
    logic               r_a_s;
    logic [2:0][15:0]   r_a_nrm;
    logic [31:0]        r_a_pdf;

    assign lp[0] = i_in.data.light_point_x;
    assign lp[1] = i_in.data.light_point_y;
    assign lp[2] = i_in.data.light_point_z;
    assign hp[0] = i_in.data.hit_x;
    assign hp[1] = i_in.data.hit_y;
    assign hp[2] = i_in.data.hit_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dd[k]    = {lp[k][31], lp[k]} - {hp[k][31], hp[k]};
            dneg[k]  = -dd[k];
            n_a_m[k] = dd[k][32] ? dneg[k][31:0] : dd[k][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_in.valid;
        end
        if (en) begin
            r_a_m      <= n_a_m;
            r_a_neg    <= {dd[2][32], dd[1][32], dd[0][32]};
            r_a_s      <= n_a_m[0][31] | n_a_m[1][31] | n_a_m[2][31];
            r_a_nrm    <= {i_in.data.light_normal_z, i_in.data.light_normal_y,
                           i_in.data.light_normal_x};
            r_a_pdf    <= i_in.data.area_pdf;
        end
    end

    // Stage B: squares of the scaled magnitudes
    logic [30:0]        ms   [3];
    logic [61:0]        msq  [3];
    logic               r_b_v;
    logic [61:0]        r_b_sq [3];
    logic [2:0][30:0]   r_b_ms;
    logic [2:0]         r_b_neg;
    logic               r_b_s;
    logic [2:0][15:0]   r_b_nrm;
    logic [31:0]        r_b_pdf;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ms[k]  = r_a_s ? r_a_m[k][31:1] : r_a_m[k][30:0];
            msq[k] = ms[k] * ms[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_a_v;
        end
        if (en) begin
            r_b_sq  <= msq;
            r_b_ms  <= {ms[2], ms[1], ms[0]};
            r_b_neg <= r_a_neg;
            r_b_s   <= r_a_s;
            r_b_nrm <= r_a_nrm;
            r_b_pdf <= r_a_pdf;
        end
    end

    // Stage C: squared length
    logic       r_c_v;
    t_sqrt_side r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_b_v;
        end
        if (en) begin
            r_c_side.sq  <= 64'(r_b_sq[0]) + 64'(r_b_sq[1]) + 64'(r_b_sq[2]);
            r_c_side.ms  <= r_b_ms;
            r_c_side.neg <= r_b_neg;
            r_c_side.s   <= r_b_s;
            r_c_side.nrm <= r_b_nrm;
            r_c_side.pdf <= r_b_pdf;
        end
    end

    logic                        sq_v;
    logic [alss_pkg::ROOT_W-1:0] sq_root;
    t_sqrt_side                  sq_side;

    alss_sqrt #(
        .SIDE_W ($bits(t_sqrt_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_v),
        .i_sq    (r_c_side.sq),
        .i_side  (r_c_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage D: rounded direction numerators
    logic       r_d_v;
    logic [63:0] r_d_num [3];
    t_dir_side  r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= sq_v;
        end
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_d_num[k] <= (64'(sq_side.ms[k]) << UNIT_FRAC_BITS) + 64'(sq_root >> 1);
            end
            r_d_side.neg <= sq_side.neg;
            r_d_side.s   <= sq_side.s;
            r_d_side.len <= sq_root;
            r_d_side.sq  <= sq_side.sq;
            r_d_side.nrm <= sq_side.nrm;
            r_d_side.pdf <= sq_side.pdf;
        end
    end

    logic            dv_v;
    logic [QD-1:0]   dv_q [3];
    t_dir_side       dv_side;

    alss_div #(
        .NUM_W  (64),
        .DEN_W  (32),
        .Q_BITS (QD),
        .LANES  (3),
        .SIDE_W ($bits(t_dir_side))
    ) u_dir_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_num   (r_d_num),
        .i_den   (r_d_side.len),
        .i_side  (r_d_side),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_side  (dv_side)
    );

    // Stage E: signed, clamped direction; shadow limit; pdf partial products
    logic [31:0]        qe    [3];
    logic [15:0]        n_dir [3];
    logic [33:0]        len_full;
    logic signed [34:0] mint_w;
    logic [31:0]        n_mint;
    logic               r_e_v;
    logic [2:0][15:0]   r_e_dir;
    logic [31:0]        r_e_mint;
    logic [63:0]        r_e_plo;
    logic [63:0]        r_e_phi;
    logic [2:0][15:0]   r_e_nrm;
    logic               r_e_s;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qe[k] = 32'(dv_q[k]);
            if (dv_side.len == '0) begin
                n_dir[k] = '0;
            end else if (dv_side.neg[k]) begin
                n_dir[k] = (qe[k] >= 32'd32768) ? 16'h8000 : 16'(-qe[k]);
            end else begin
                n_dir[k] = (qe[k] > 32'd32767) ? 16'h7FFF : qe[k][15:0];
            end
        end
        len_full = 34'(dv_side.len) << dv_side.s;
        mint_w   = $signed({1'b0, len_full}) - $signed({19'd0, r_eps});
        n_mint   = (mint_w > 35'sd2147483647) ? 32'h7FFF_FFFF : mint_w[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= dv_v;
        end
        if (en) begin
            r_e_dir  <= {n_dir[2], n_dir[1], n_dir[0]};
            r_e_mint <= n_mint;
            r_e_plo  <= dv_side.pdf * dv_side.sq[31:0];
            r_e_phi  <= dv_side.pdf * dv_side.sq[63:32];
            r_e_nrm  <= dv_side.nrm;
            r_e_s    <= dv_side.s;
        end
    end

    // Stage F: cosine products, full denominator
    logic               r_f_v;
    logic signed [31:0] r_f_prod [3];
    logic [95:0]        r_f_den;
    logic [2:0][15:0]   r_f_dir;
    logic [31:0]        r_f_mint;
    logic               r_f_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= r_e_v;
        end
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_f_prod[k] <= $signed(r_e_dir[k]) * $signed(r_e_nrm[k]);
            end
            r_f_den  <= {r_e_phi, 32'd0} + {32'd0, r_e_plo};
            r_f_dir  <= r_e_dir;
            r_f_mint <= r_e_mint;
            r_f_s    <= r_e_s;
        end
    end

    // Stage G: cosine
    logic signed [34:0] cosw;
    logic               r_g_v;
    logic [31:0]        r_g_cos;
    logic               r_g_pos;
    logic [95:0]        r_g_den;
    logic [2:0][15:0]   r_g_dir;
    logic [31:0]        r_g_mint;
    logic               r_g_s;

    assign cosw = -(35'(r_f_prod[0]) + 35'(r_f_prod[1]) + 35'(r_f_prod[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (en) begin
            r_g_v <= r_f_v;
        end
        if (en) begin
            r_g_cos  <= cosw[31:0];
            r_g_pos  <= cosw > 35'sd0;
            r_g_den  <= r_f_den;
            r_g_dir  <= r_f_dir;
            r_g_mint <= r_f_mint;
            r_g_s    <= r_f_s;
        end
    end

    // Stage H: colour numerators
    logic               r_h_v;
    logic [47:0]        r_h_n [3];
    logic               r_h_pos;
    logic [95:0]        r_h_den;
    logic [2:0][15:0]   r_h_dir;
    logic [31:0]        r_h_mint;
    logic               r_h_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (en) begin
            r_h_v <= r_g_v;
        end
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_h_n[k] <= r_light[k] * r_g_cos;
            end
            r_h_pos  <= r_g_pos;
            r_h_den  <= r_g_den;
            r_h_dir  <= r_g_dir;
            r_h_mint <= r_g_mint;
            r_h_s    <= r_g_s;
        end
    end

    // Stage I: apply the binary exponent to numerator or denominator
    logic               r_i_v;
    logic [NUM_C-1:0]   r_i_num [3];
    logic [DEN_C-1:0]   r_i_den;
    t_col_side          r_i_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else if (en) begin
            r_i_v <= r_h_v;
        end
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_i_num[k]     <= r_h_s ? (NUM_C'(r_h_n[k]) << UP_S1)
                                        : (NUM_C'(r_h_n[k]) << UP_S0);
                r_i_side.nz[k] <= r_h_n[k] == '0;
            end
            r_i_den       <= r_h_s ? (DEN_C'(r_h_den) << DN_S1) : (DEN_C'(r_h_den) << DN_S0);
            r_i_side.pos  <= r_h_pos;
            r_i_side.dir  <= r_h_dir;
            r_i_side.mint <= r_h_mint;
        end
    end

    logic          cv_v;
    logic [QC-1:0] cv_q [3];
    t_col_side     cv_side;

    alss_div #(
        .NUM_W  (NUM_C),
        .DEN_W  (DEN_C),
        .Q_BITS (QC),
        .LANES  (3),
        .SIDE_W ($bits(t_col_side))
    ) u_col_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_i_v),
        .i_num   (r_i_num),
        .i_den   (r_i_den),
        .i_side  (r_i_side),
        .o_valid (cv_v),
        .o_quo   (cv_q),
        .o_side  (cv_side)
    );

    // Output register: saturate on quotient overflow, black when facing away
    logic [31:0]         col [3];
    alss_pkg::t_out_item r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!cv_side.pos || cv_side.nz[k]) begin
                col[k] = '0;
            end else if (cv_q[k][QC-1]) begin
                col[k] = 32'hFFFF_FFFF;
            end else begin
                col[k] = cv_q[k][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= cv_v;
        end
        if (en) begin
            r_out.dir_x        <= cv_side.dir[0];
            r_out.dir_y        <= cv_side.dir[1];
            r_out.dir_z        <= cv_side.dir[2];
            r_out.shadow_min_t <= cv_side.mint;
            r_out.out_red      <= col[0];
            r_out.out_green    <= col[1];
            r_out.out_blue     <= col[2];
            r_out.facing_away  <= !cv_side.pos;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
